FILE: rtl/core/seqchk_pkg.sv
// Sequence number checker: shared types, constants and status codes.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package seqchk_pkg;

	// Width of one sequence word
	localparam int WORD_W = 64;

	// Words per packet; must be a power of two (range 1 to 65536)
	localparam int WORDS_PER_PACKET = 1024;
	localparam int PKT_SHIFT = $clog2(WORDS_PER_PACKET);
	localparam logic [WORD_W-1:0] PKT_MASK = WORD_W'(WORDS_PER_PACKET - 1);

	// Offset field carries only the low bits of the offset
	localparam int OFFSET_W = 10;

	// Marker register value after reset (".TEST." framed by newlines)
	localparam logic [WORD_W-1:0] MARKER_RESET = 64'h0A2E_5453_4554_2E0A;

	// Result classification
	typedef enum logic [1:0] {
		ST_IN_ORDER = 2'd0,
		ST_MARKER   = 2'd1,
		ST_GAP_ONE  = 2'd2,
		ST_JUMP     = 2'd3
	} status_t;

	// Beat held in the input register, handed to the check stage
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] word;
	} beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/seqchk_in_stage.sv
// Input register of the sequence number checker.
// Depends on seqchk_pkg; feeds seqchk_check.
`default_nettype none

module seqchk_in_stage (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [seqchk_pkg::WORD_W-1:0] word,
	input  wire logic                     take,
	output seqchk_pkg::beat_t             beat_s1
);
	import seqchk_pkg::*;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              load;

	// Room when empty or when the held beat moves on this cycle
	assign in_ready = !valid_s1 || take;
	assign load     = in_valid && in_ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			word_s1 <= word;
		end
	end

	assign beat_s1.valid = valid_s1;
	assign beat_s1.word  = word_s1;

endmodule

`default_nettype wire

FILE: rtl/core/seqchk_check.sv
// Check stage: marker register, running state and the result register.
// Depends on seqchk_pkg; takes beats from seqchk_in_stage.
`default_nettype none

module seqchk_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [seqchk_pkg::WORD_W-1:0] cfg_wr_data,
	input  wire seqchk_pkg::beat_t             beat_s1,
	output logic                               take,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         status,
	output logic [seqchk_pkg::WORD_W-1:0]      expected_value,
	output logic [seqchk_pkg::WORD_W-1:0]      difference,
	output logic [seqchk_pkg::WORD_W-1:0]      word_position,
	output logic [seqchk_pkg::WORD_W-1:0]      packet_index,
	output logic [seqchk_pkg::OFFSET_W-1:0]    offset_in_packet,
	output logic [seqchk_pkg::WORD_W-1:0]      error_count,
	output logic [seqchk_pkg::WORD_W-1:0]      marker_count,
	output logic [seqchk_pkg::WORD_W-1:0]      last_checked
);
	import seqchk_pkg::*;

	// Configuration and running state
	logic [WORD_W-1:0] marker_q;
	logic [WORD_W-1:0] expected_next_q;
	logic              seeded_q;
	logic [WORD_W-1:0] words_seen_q;
	logic [WORD_W-1:0] errors_q;
	logic [WORD_W-1:0] markers_q;
	logic [WORD_W-1:0] last_good_q;

	// Result register
	logic              out_valid_q;
	status_t           status_q;
	logic [WORD_W-1:0] expect_q;
	logic [WORD_W-1:0] diff_q;
	logic [WORD_W-1:0] pos_q;
	logic [WORD_W-1:0] pkt_q;
	logic [OFFSET_W-1:0] offset_q;

	// Check logic
	logic              is_marker;
	logic              mismatch;
	logic [WORD_W-1:0] expect_c;
	logic [WORD_W-1:0] diff_c;
	status_t           status_c;

	assign take = beat_s1.valid && (!out_valid_q || out_ready);

	always_comb begin
		expect_c  = seeded_q ? expected_next_q : beat_s1.word;
		is_marker = (beat_s1.word == marker_q);
		mismatch  = !is_marker && (beat_s1.word != expect_c);
		diff_c    = (beat_s1.word > expect_c) ? (beat_s1.word - expect_c)
		                                      : (expect_c - beat_s1.word);
		if (is_marker) begin
			status_c = ST_MARKER;
		end else if (!mismatch) begin
			status_c = ST_IN_ORDER;
		end else if (diff_c == WORD_W'(1)) begin
			status_c = ST_GAP_ONE;
		end else begin
			status_c = ST_JUMP;
		end
	end

	// Marker register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_wr_en) begin
			marker_q <= cfg_wr_data;
		end
	end

	// Running state; on a match word + 1 equals expected + 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_next_q <= '0;
			seeded_q        <= 1'b0;
			words_seen_q    <= '0;
			errors_q        <= '0;
			markers_q       <= '0;
			last_good_q     <= '0;
		end else if (take) begin
			expected_next_q <= is_marker ? (expect_c + WORD_W'(1))
			                             : (beat_s1.word + WORD_W'(1));
			seeded_q        <= 1'b1;
			words_seen_q    <= words_seen_q + WORD_W'(1);
			errors_q        <= errors_q + WORD_W'(mismatch);
			markers_q       <= markers_q + WORD_W'(is_marker);
			if (!is_marker) begin
				last_good_q <= beat_s1.word;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= beat_s1.valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_c;
			expect_q <= expect_c;
			diff_q   <= mismatch ? diff_c : '0;
			pos_q    <= words_seen_q;
			pkt_q    <= (words_seen_q >> PKT_SHIFT) + WORD_W'(1);
			offset_q <= OFFSET_W'(words_seen_q & PKT_MASK);
		end
	end

	// Counts and last word live in the state registers, which hold while stalled
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign expected_value   = expect_q;
	assign difference       = diff_q;
	assign word_position    = pos_q;
	assign packet_index     = pkt_q;
	assign offset_in_packet = offset_q;
	assign error_count      = errors_q;
	assign marker_count     = markers_q;
	assign last_checked     = last_good_q;

	// A marker beat bumps the marker count by exactly one
	a_marker_count: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_marker |=> markers_q == $past(markers_q) + WORD_W'(1))
		else $error("marker count did not advance on a marker beat");

	// A non-marker beat resynchronizes to word + 1
	a_resync: assert property (@(posedge clk) disable iff (!arst_n)
		take && !is_marker |=> expected_next_q == $past(beat_s1.word) + WORD_W'(1))
		else $error("expected value not resynchronized");

	// A gap of one reports a difference of one
	a_gap_diff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_GAP_ONE |-> diff_q == WORD_W'(1))
		else $error("gap of one with wrong difference");

	// An in-order result checked exactly the expected word
	a_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_IN_ORDER |-> diff_q == '0 && last_good_q == expect_q)
		else $error("in-order result inconsistent");

	// Word position follows the running count
	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> pos_q + WORD_W'(1) == words_seen_q)
		else $error("position out of step with word count");

endmodule

`default_nettype wire

FILE: rtl/core/sequence_number_checker.sv
// Sequence number checker, top level.
// Depends on seqchk_pkg, seqchk_in_stage and seqchk_check.
//
// Checks a stream of 64-bit words that should count up by one and gives one
// result beat per input beat. The first word after reset seeds the expected
// value; a word equal to the marker register counts as a marker and advances
// the expected value; any other mismatch counts as an error (gap of one or
// larger jump, absolute difference reported) and resynchronizes to word + 1.
// All counters wrap at 2^64. Throughput is one word per cycle unless the
// output stalls. The word is registered in the input register, then
// compared and counted into the result register once take is high.
// Two beats can be held while the output stalls, after which in_ready drops.
// The marker register is written with cfg_wr_en/cfg_wr_data and should only
// change while idle.
`default_nettype none

module sequence_number_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [seqchk_pkg::WORD_W-1:0] cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [seqchk_pkg::WORD_W-1:0] word,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         status,
	output logic [seqchk_pkg::WORD_W-1:0]      expected_value,
	output logic [seqchk_pkg::WORD_W-1:0]      difference,
	output logic [seqchk_pkg::WORD_W-1:0]      word_position,
	output logic [seqchk_pkg::WORD_W-1:0]      packet_index,
	output logic [seqchk_pkg::OFFSET_W-1:0]    offset_in_packet,
	output logic [seqchk_pkg::WORD_W-1:0]      error_count,
	output logic [seqchk_pkg::WORD_W-1:0]      marker_count,
	output logic [seqchk_pkg::WORD_W-1:0]      last_checked
);
	import seqchk_pkg::*;

	beat_t beat_s1;
	logic  take;

	// Input register
	seqchk_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.word     (word),
		.take     (take),
		.beat_s1  (beat_s1)
	);

	// Compare, classify and count
	seqchk_check u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.beat_s1          (beat_s1),
		.take             (take),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.expected_value   (expected_value),
		.difference       (difference),
		.word_position    (word_position),
		.packet_index     (packet_index),
		.offset_in_packet (offset_in_packet),
		.error_count      (error_count),
		.marker_count     (marker_count),
		.last_checked     (last_checked)
	);

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for sequence_number_checker: directed and random word streams, scored
// against an in-bench model of the sequence check. Depends on seqchk_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
	import seqchk_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	// One expected result beat
	typedef struct {
		status_t               status;
		logic [WORD_W-1:0]     expected_value;
		logic [WORD_W-1:0]     difference;
		logic [WORD_W-1:0]     word_position;
		logic [WORD_W-1:0]     packet_index;
		logic [OFFSET_W-1:0]   offset_in_packet;
		logic [WORD_W-1:0]     error_count;
		logic [WORD_W-1:0]     marker_count;
		logic [WORD_W-1:0]     last_checked;
	} seq_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [WORD_W-1:0]     cfg_wr_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [WORD_W-1:0]     word;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            status;
	logic [WORD_W-1:0]     expected_value;
	logic [WORD_W-1:0]     difference;
	logic [WORD_W-1:0]     word_position;
	logic [WORD_W-1:0]     packet_index;
	logic [OFFSET_W-1:0]   offset_in_packet;
	logic [WORD_W-1:0]     error_count;
	logic [WORD_W-1:0]     marker_count;
	logic [WORD_W-1:0]     last_checked;

	// Model state of the checker
	logic [WORD_W-1:0]     mdl_marker;
	logic [WORD_W-1:0]     mdl_expect_next;
	logic                  mdl_seeded;
	logic [WORD_W-1:0]     mdl_words;
	logic [WORD_W-1:0]     mdl_errors;
	logic [WORD_W-1:0]     mdl_markers;
	logic [WORD_W-1:0]     mdl_last_good;

	seq_result_t           pending_results[$];

	int                    fail_count = 0;
	int                    results_checked = 0;
	int                    marker_settings = 0;
	bit                    idle_on = 1'b1;
	int                    hold_req = 0;
	int                    hold_seen = 0;
	int                    hold_left = 0;
	int                    stall_left = 0;

	sequence_number_checker i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.word             (word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.expected_value   (expected_value),
		.difference       (difference),
		.word_position    (word_position),
		.packet_index     (packet_index),
		.offset_in_packet (offset_in_packet),
		.error_count      (error_count),
		.marker_count     (marker_count),
		.last_checked     (last_checked)
	);

	always #10 clk = ~clk;

	// Sequence check model: one word in, one result out, state advanced
	function automatic seq_result_t predict_check(input logic [WORD_W-1:0] w);
		seq_result_t       r;
		logic [WORD_W-1:0] pos;
		logic [WORD_W-1:0] wpp;
		logic [WORD_W-1:0] exp_v;
		pos = mdl_words;
		wpp = WORD_W'(WORDS_PER_PACKET);
		if (!mdl_seeded) begin
			mdl_expect_next = w;
			mdl_seeded = 1'b1;
		end
		exp_v = mdl_expect_next;
		r.difference = '0;
		r.status = ST_IN_ORDER;
		if (w == mdl_marker) begin
			mdl_markers = mdl_markers + 1;
			mdl_expect_next = exp_v + 1;
			r.status = ST_MARKER;
		end else begin
			if (w != exp_v) begin
				r.difference = (w > exp_v) ? (w - exp_v) : (exp_v - w);
				mdl_errors = mdl_errors + 1;
				r.status = (r.difference == 1) ? ST_GAP_ONE : ST_JUMP;
				mdl_expect_next = w + 1;
			end else begin
				mdl_expect_next = exp_v + 1;
			end
			mdl_last_good = w;
		end
		r.expected_value = exp_v;
		r.word_position = pos;
		r.packet_index = pos / wpp + 1;
		r.offset_in_packet = OFFSET_W'(pos % wpp);
		r.error_count = mdl_errors;
		r.marker_count = mdl_markers;
		r.last_checked = mdl_last_good;
		mdl_words = pos + 1;
		return r;
	endfunction

	// Offer one word, optionally after an idle burst; valid stays high after accept
	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		word <= w;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_check(w));
	endtask

	// Stop offering and wait until every expected beat has come out
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_marker(input logic [WORD_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mdl_marker = v;
		marker_settings++;
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Receiver: random stall bursts, plus a long hold when a test asks for one
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (idle_on && stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result scoreboard
	always @(posedge clk) begin : score
		seq_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation pending");
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				results_checked++;
				check_field("status", WORD_W'(exp_r.status), WORD_W'(status));
				check_field("expected_value", exp_r.expected_value, expected_value);
				check_field("difference", exp_r.difference, difference);
				check_field("word_position", exp_r.word_position, word_position);
				check_field("packet_index", exp_r.packet_index, packet_index);
				check_field("offset_in_packet", WORD_W'(exp_r.offset_in_packet),
					WORD_W'(offset_in_packet));
				check_field("error_count", exp_r.error_count, error_count);
				check_field("marker_count", exp_r.marker_count, marker_count);
				check_field("last_checked", exp_r.last_checked, last_checked);
			end
		end
	end

	// First word after reset equals the marker: seeds and counts as marker
	task automatic test_first_word_marker;
		send_word(MARKER_RESET);
		send_word(MARKER_RESET + 1);
		send_word(MARKER_RESET + 2);
		// marker mid-stream: expected advances, last_checked holds
		send_word(MARKER_RESET);
		send_word(MARKER_RESET + 4);
		drain();
	endtask

	// Wrap of the expected value, maximal difference, gaps of one both ways
	task automatic test_wrap_and_errors;
		send_word(ALL_ONES - 1);
		send_word(ALL_ONES);
		send_word(ALL_ONES);
		send_word('0);
		send_word(64'd2);
		send_word(64'd2);
		send_word(64'd3);
		drain();
	endtask

	// Marker register at its extremes and a random value, then back to reset value
	task automatic test_marker_settings;
		logic [WORD_W-1:0] m;
		write_marker('0);
		send_word('0);
		send_word(64'd5);
		drain();
		write_marker(ALL_ONES);
		send_word(ALL_ONES);
		send_word(64'd7);
		drain();
		m = {$urandom(), $urandom()};
		write_marker(m);
		send_word(m);
		send_word(mdl_expect_next);
		drain();
		write_marker(MARKER_RESET);
	endtask

	// Receiver holds off while the sender keeps offering; input must stall
	task automatic test_backpressure;
		bit saved_idle;
		saved_idle = idle_on;
		idle_on = 1'b0;
		hold_req++;
		repeat (80) send_word(mdl_expect_next);
		idle_on = saved_idle;
		drain();
	endtask

	// Mostly well-formed counting with markers, gaps, jumps and random noise
	task automatic test_random_stream(input int n_items, input logic [WORD_W-1:0] marker,
			input logic [WORD_W-1:0] start);
		int                r;
		logic [WORD_W-1:0] w;
		write_marker(marker);
		send_word(start);
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			if (r < 68)
				w = mdl_expect_next;
			else if (r < 75)
				w = mdl_marker;
			else if (r < 81)
				w = mdl_expect_next + 1;
			else if (r < 86)
				w = mdl_expect_next - 1;
			else if (r < 90)
				w = mdl_expect_next + WORD_W'($urandom_range(2, 1000));
			else if (r < 93)
				w = mdl_expect_next - WORD_W'($urandom_range(2, 1000));
			else
				w = {$urandom(), $urandom()};
			send_word(w);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		word = '0;
		out_ready = 1'b0;
		mdl_marker = MARKER_RESET;
		mdl_expect_next = '0;
		mdl_seeded = 1'b0;
		mdl_words = '0;
		mdl_errors = '0;
		mdl_markers = '0;
		mdl_last_good = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_word_marker();
		test_wrap_and_errors();
		test_marker_settings();
		test_backpressure();
		test_random_stream(420, {$urandom(), $urandom()}, {$urandom(), $urandom()});
		test_random_stream(420, mdl_expect_next + 60, mdl_expect_next);
		test_random_stream(420, MARKER_RESET, MARKER_RESET - 30);
		// last part runs without idling on either side
		idle_on = 1'b0;
		test_random_stream(420, ALL_ONES, ALL_ONES - 200);

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		$display("Checked %0d result beats over %0d words (%0d errors, %0d markers) ",
			results_checked, mdl_words, mdl_errors, mdl_markers);
		$display("with %0d marker register settings, packet boundaries and a long output hold.",
			marker_settings);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/seqchk_pkg.sv
rtl/core/seqchk_in_stage.sv
rtl/core/seqchk_check.sv
rtl/core/sequence_number_checker.sv
verif/tb.sv
